// File: rtl/core/mrd_pkg.sv
`default_nettype none

package mrd_pkg;

	// default route table depth
	localparam int unsigned RT_DEPTH_DEF = 64;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_RANK  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DATA_TYPE = 1'd1;

	// result kinds
	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	// error codes
	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_INCOMPLETE = 3'd1;
	localparam logic [2:0] ERR_MARKER     = 3'd2;
	localparam logic [2:0] ERR_IP         = 3'd3;
	localparam logic [2:0] ERR_DST        = 3'd4;
	localparam logic [2:0] ERR_TYPE       = 3'd5;

	localparam logic [7:0] MARKER_BYTE = 8'h96;
	localparam logic [7:0] KEEP_ALL    = 8'hFF;

	// Work entry between front and back.
	// Payload: word = data, aux = keep, last = packet end.
	// Header:  word = {element count, peer rank}, aux = call code.
	// Error:   code = error code.
	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] word;
		logic [7:0]  aux;
		logic        last;
		logic [2:0]  code;
	} mrd_entry_t;

endpackage

`default_nettype wire

// File: rtl/core/mrd_front.sv
`default_nettype none

module mrd_front #(
	parameter int unsigned ROUTE_TABLE_DEPTH = mrd_pkg::RT_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               command,
	input  wire logic [63:0]        word_data,
	input  wire logic [7:0]         word_keep,
	input  wire logic               word_last,
	input  wire logic [31:0]        source_ip,
	input  wire logic [5:0]         table_index,
	input  wire logic [31:0]        table_value,
	input  wire logic [31:0]        own_rank,
	input  wire logic [7:0]         data_type_code,
	input  wire logic               q_full,
	output logic                    push,
	output mrd_pkg::mrd_entry_t     push_entry
);
	import mrd_pkg::*;

	localparam int unsigned AW = $clog2(ROUTE_TABLE_DEPTH);
	localparam logic [31:0] DEPTH_W = 32'(ROUTE_TABLE_DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(ROUTE_TABLE_DEPTH - 1);

	localparam logic [1:0] PH_HEADER  = 2'd0;
	localparam logic [1:0] PH_PAYLOAD = 2'd1;
	localparam logic [1:0] PH_DISCARD = 2'd2;

	function automatic logic [31:0] be32(input logic [31:0] le);
		be32 = {le[7:0], le[15:8], le[23:16], le[31:24]};
	endfunction

	logic [1:0]  phase_q;
	logic [1:0]  hidx_q;
	logic [63:0] hdr_q [3];
	logic        hdr_pend_s1;
	logic [63:0] w3_s1;
	logic [31:0] ip_s1;
	logic [31:0] rt_rd_s1;
	logic        clr_busy_q;
	logic [AW-1:0] clr_addr_q;
	logic [31:0] route_mem [ROUTE_TABLE_DEPTH];

	logic acc, net, tw, tw_in_range, hdr_bad, hdr_fin, s1_go;
	logic [31:0] src_w, dst_w, size_w;
	logic marker_ok, ip_ok;
	logic [2:0] s1_code;

	assign in_ready    = !clr_busy_q && !hdr_pend_s1 && !q_full;
	assign acc         = in_valid && in_ready;
	assign net         = acc && !command;
	assign tw          = acc && command;
	assign tw_in_range = 32'(table_index) < DEPTH_W;
	assign hdr_bad     = (word_keep != KEEP_ALL) || word_last;
	assign hdr_fin     = net && (phase_q == PH_HEADER) && !hdr_bad && (hidx_q == 2'd3);
	assign s1_go       = hdr_pend_s1 && !q_full;

	assign dst_w  = be32(hdr_q[0][63:32]);
	assign src_w  = be32(hdr_q[1][31:0]);
	assign size_w = be32(hdr_q[1][63:32]);

	assign marker_ok = (hdr_q[0][31:0] == {4{MARKER_BYTE}}) &&
		(w3_s1[63:32] == {4{MARKER_BYTE}}) &&
		(hdr_q[2][63:16] == '0) && (w3_s1[31:0] == '0);
	assign ip_ok = (src_w < DEPTH_W) && (rt_rd_s1 == ip_s1);

	always_comb begin
		priority if (!marker_ok) begin
			s1_code = ERR_MARKER;
		end else if (!ip_ok) begin
			s1_code = ERR_IP;
		end else if (dst_w != own_rank) begin
			s1_code = ERR_DST;
		end else if (hdr_q[2][15:8] != data_type_code) begin
			s1_code = ERR_TYPE;
		end else begin
			s1_code = ERR_NONE;
		end
	end

	always_comb begin
		push       = 1'b0;
		push_entry = '0;
		if (s1_go) begin
			push = 1'b1;
			if (s1_code != ERR_NONE) begin
				push_entry.kind = KIND_ERROR;
				push_entry.code = s1_code;
			end else begin
				push_entry.kind = KIND_HEADER;
				push_entry.word = {size_w, src_w};
				push_entry.aux  = hdr_q[2][7:0];
			end
		end else if (net && (phase_q == PH_PAYLOAD) && (word_keep != '0)) begin
			push            = 1'b1;
			push_entry.kind = KIND_PAYLOAD;
			push_entry.word = word_data;
			push_entry.aux  = word_keep;
			push_entry.last = word_last;
		end else if (net && (phase_q == PH_HEADER) && hdr_bad) begin
			push            = 1'b1;
			push_entry.kind = KIND_ERROR;
			push_entry.code = ERR_INCOMPLETE;
		end
	end

	// route table: clearing pass after reset, then table writes
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			route_mem[clr_addr_q] <= '0;
		end else if (tw && tw_in_range) begin
			route_mem[AW'(table_index)] <= table_value;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_fin) begin
			rt_rd_s1 <= route_mem[AW'(src_w)];
			w3_s1    <= word_data;
			ip_s1    <= source_ip;
		end
	end

	always_ff @(posedge clk) begin
		if (net && (phase_q == PH_HEADER) && !hdr_bad && (hidx_q != 2'd3)) begin
			hdr_q[hidx_q] <= word_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == LAST_ADDR) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			hidx_q      <= '0;
			hdr_pend_s1 <= 1'b0;
		end else if (s1_go) begin
			hdr_pend_s1 <= 1'b0;
			phase_q     <= (s1_code == ERR_NONE) ? PH_PAYLOAD : PH_DISCARD;
		end else if (net) begin
			unique case (phase_q)
				PH_PAYLOAD, PH_DISCARD: begin
					if (word_last) begin
						phase_q <= PH_HEADER;
					end
				end
				PH_HEADER: begin
					if (hdr_bad) begin
						hidx_q  <= '0;
						phase_q <= word_last ? PH_HEADER : PH_DISCARD;
					end else if (hidx_q == 2'd3) begin
						hidx_q      <= '0;
						hdr_pend_s1 <= 1'b1;
					end else begin
						hidx_q <= hidx_q + 2'd1;
					end
				end
				default: begin
					phase_q <= PH_HEADER;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/mrd_queue.sv
`default_nettype none

module mrd_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire mrd_pkg::mrd_entry_t  push_entry,
	output logic                      full,
	input  wire logic                 pop,
	output logic                      head_valid,
	output mrd_pkg::mrd_entry_t       head
);
	import mrd_pkg::*;

	mrd_entry_t slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_pop;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head       = slot_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/mrd_back.sv
`default_nettype none

module mrd_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 q_valid,
	input  wire mrd_pkg::mrd_entry_t  q_head,
	output logic                      q_pop,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [1:0]                result_kind,
	output logic [7:0]                payload_byte,
	output logic                      byte_last,
	output logic [7:0]                call_code,
	output logic [31:0]               element_count,
	output logic [31:0]               peer_rank,
	output logic [2:0]                error_code,
	output logic [31:0]               error_count,
	output logic                      result_last
);
	import mrd_pkg::*;

	mrd_entry_t  cur_q;
	logic        cur_valid_q;
	logic [7:0]  mask_q;
	logic [31:0] cnt_q;

	logic        emit, done;
	logic [2:0]  lane;
	logic [7:0]  rem;
	logic [31:0] cnt_next;

	always_comb begin
		lane = '0;
		for (int i = 7; i >= 0; i--) begin
			if (mask_q[i]) begin
				lane = 3'(i);
			end
		end
	end

	assign rem      = mask_q & (mask_q - 8'd1);
	assign done     = (cur_q.kind != KIND_PAYLOAD) || (rem == '0);
	assign emit     = cur_valid_q && (!out_valid || out_ready);
	assign q_pop    = q_valid && (!cur_valid_q || (emit && done));
	assign cnt_next = (cnt_q == '1) ? cnt_q : cnt_q + 32'd1;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q  <= q_head;
			mask_q <= q_head.aux;
		end else if (emit) begin
			mask_q <= rem;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_kind   <= cur_q.kind;
			payload_byte  <= '0;
			byte_last     <= 1'b0;
			call_code     <= '0;
			element_count <= '0;
			peer_rank     <= '0;
			error_code    <= ERR_NONE;
			error_count   <= cnt_q;
			result_last   <= done;
			unique case (cur_q.kind)
				KIND_PAYLOAD: begin
					payload_byte <= cur_q.word[{lane, 3'b000} +: 8];
					byte_last    <= cur_q.last && (rem == '0);
				end
				KIND_HEADER: begin
					call_code     <= cur_q.aux;
					element_count <= cur_q.word[63:32];
					peer_rank     <= cur_q.word[31:0];
				end
				KIND_ERROR: begin
					error_code  <= cur_q.code;
					error_count <= cnt_next;
				end
				default: begin
					result_last <= 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			out_valid   <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (q_pop) begin
				cur_valid_q <= 1'b1;
			end else if (emit && done) begin
				cur_valid_q <= 1'b0;
			end
			if (emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (emit && (cur_q.kind == KIND_ERROR)) begin
				cnt_q <= cnt_next;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/message_receive_deframer_core.sv
// Path: a payload word or broken-header error passes the queue, the back end's current
//   entry and the output register; header results and check errors pass check registers first.
// Throughput: one result beat per cycle while out_ready allows; one beat per kept byte
//   (up to 8); after the fourth header word in_ready stays low until its result is queued.
// Reset: arst_n clears all control state, then a clearing pass zeroes the route table
//   with in_ready low; configuration writes are taken throughout.
`default_nettype none

module message_receive_deframer_core #(
	parameter int unsigned ROUTE_TABLE_DEPTH = mrd_pkg::RT_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input channel
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           command,
	input  wire logic [63:0]                    word_data,
	input  wire logic [7:0]                     word_keep,
	input  wire logic                           word_last,
	input  wire logic [31:0]                    source_ip,
	input  wire logic [5:0]                     table_index,
	input  wire logic [31:0]                    table_value,
	// configuration write port
	input  wire logic                           cfg_we,
	input  wire logic [mrd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [mrd_pkg::CFG_DATA_W-1:0] cfg_data,
	// result channel
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [1:0]                          result_kind,
	output logic [7:0]                          payload_byte,
	output logic                                byte_last,
	output logic [7:0]                          call_code,
	output logic [31:0]                         element_count,
	output logic [31:0]                         peer_rank,
	output logic [2:0]                          error_code,
	output logic [31:0]                         error_count,
	output logic                                result_last
);
	import mrd_pkg::*;

	// Configuration registers: own rank and the type byte that marks data.
	logic [31:0] own_rank_q;
	logic [7:0]  data_type_q;

	// Front to queue, queue to back.
	logic       push;
	mrd_entry_t push_entry;
	logic       q_full;
	logic       q_pop;
	logic       q_valid;
	mrd_entry_t q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_rank_q  <= '0;
			data_type_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OWN_RANK:  own_rank_q  <= cfg_data[31:0];
				CFG_DATA_TYPE: data_type_q <= cfg_data[7:0];
				default: begin
					// unknown register: drop the write
				end
			endcase
		end
	end

	// Front end: take every beat, write the route table, collect and check the
	// header, and hand header results, errors and payload words to the queue.
	// Empty payload words and discarded words never reach the queue.
	mrd_front #(
		.ROUTE_TABLE_DEPTH(ROUTE_TABLE_DEPTH)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.word_data      (word_data),
		.word_keep      (word_keep),
		.word_last      (word_last),
		.source_ip      (source_ip),
		.table_index    (table_index),
		.table_value    (table_value),
		.own_rank       (own_rank_q),
		.data_type_code (data_type_q),
		.q_full         (q_full),
		.push           (push),
		.push_entry     (push_entry)
	);

	// Two-entry queue: lets the front keep taking beats while the back end is
	// still splitting an earlier word into bytes.
	mrd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (q_head)
	);

	// Back end: one result beat per cycle into the output register while out_ready allows,
	// error counting (saturating) in result order.
	mrd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result_kind   (result_kind),
		.payload_byte  (payload_byte),
		.byte_last     (byte_last),
		.call_code     (call_code),
		.element_count (element_count),
		.peer_rank     (peer_rank),
		.error_code    (error_code),
		.error_count   (error_count),
		.result_last   (result_last)
	);

	// The error count only moves when an error result is shown.
	a_count_moves_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(error_count) |-> (result_kind == KIND_ERROR))
		else $error("error count changed without an error result");

	// A message end marker sits on a payload byte that also ends its word.
	a_byte_last_ends_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && byte_last) |-> (result_last && (result_kind == KIND_PAYLOAD)))
		else $error("byte_last on a result that does not end a payload word");

	// Error results carry a code, others none.
	a_code_matches_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((result_kind == KIND_ERROR) == (error_code != ERR_NONE)))
		else $error("error code does not match result kind");

endmodule

`default_nettype wire

// File: tb/sv/message_receive_deframer_core_tb.sv
module message_receive_deframer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mrd_pkg::*;

	localparam int unsigned RT_DEPTH     = 64;
	localparam int unsigned HOLD_CYCLES  = 400;     // one long receiver hold-off
	localparam int unsigned HOLD_AFTER   = 40;      // accepted beats before the hold starts
	localparam int unsigned DRAIN_CYCLES = 20;      // idle time after the last result, before register writes
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned REPORT_MAX   = 10;

	// One input beat as the sender offers it.
	typedef struct packed {
		logic        cmd;
		logic [63:0] data;
		logic [7:0]  keep;
		logic        last;
		logic [31:0] ip;
		logic [5:0]  tidx;
		logic [31:0] tval;
	} rx_item_t;

	// One result beat, every field of the result channel.
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data_byte;
		logic        byte_end;
		logic [7:0]  call;
		logic [31:0] count;
		logic [31:0] peer;
		logic [2:0]  code;
		logic [31:0] errors;
		logic        res_end;
	} rx_result_t;

	typedef enum logic [1:0] {RX_HEADER, RX_BODY, RX_DROP} rx_state_t;

	// ------------------------------------------------------------------
	// DUT signals; every input starts at a known value
	// ------------------------------------------------------------------
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        command = 1'b0;
	logic [63:0] word_data = '0;
	logic [7:0]  word_keep = '0;
	logic        word_last = 1'b0;
	logic [31:0] source_ip = '0;
	logic [5:0]  table_index = '0;
	logic [31:0] table_value = '0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  result_kind;
	logic [7:0]  payload_byte;
	logic        byte_last;
	logic [7:0]  call_code;
	logic [31:0] element_count;
	logic [31:0] peer_rank;
	logic [2:0]  error_code;
	logic [31:0] error_count;
	logic        result_last;

	message_receive_deframer_core #(
		.ROUTE_TABLE_DEPTH(RT_DEPTH)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.word_data    (word_data),
		.word_keep    (word_keep),
		.word_last    (word_last),
		.source_ip    (source_ip),
		.table_index  (table_index),
		.table_value  (table_value),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_kind  (result_kind),
		.payload_byte (payload_byte),
		.byte_last    (byte_last),
		.call_code    (call_code),
		.element_count(element_count),
		.peer_rank    (peer_rank),
		.error_code   (error_code),
		.error_count  (error_count),
		.result_last  (result_last)
	);

	// ------------------------------------------------------------------
	// Shared bookkeeping
	// ------------------------------------------------------------------
	rx_item_t   beats_to_send[$];   // filled by the stimulus, drained by the driver
	rx_result_t results_due[$];     // predicted results, oldest first
	int unsigned planned_beats = 0; // beats ever queued
	int unsigned accepted_cnt = 0;  // beats taken by the block
	int unsigned mismatch_cnt = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;
	int unsigned cycle_cnt = 0;

	// Deframer image kept by the predictor
	logic [31:0] node_rank = '0;
	logic [7:0]  type_code = '0;
	rx_state_t   rx_state = RX_HEADER;
	int unsigned hdr_cnt = 0;
	logic [63:0] hdr_words[3];
	logic [31:0] route_ip[RT_DEPTH];
	logic [31:0] err_total = '0;

	// Stimulus side: what the route table will hold once the queued writes land,
	// so that well-formed packets can carry the right source address
	logic [31:0] ip_of_rank[RT_DEPTH];

	initial begin
		for (int i = 0; i < RT_DEPTH; i++) begin
			route_ip[i] = '0;
			ip_of_rank[i] = '0;
		end
	end

	// ------------------------------------------------------------------
	// Clock and watchdog
	// ------------------------------------------------------------------
	initial begin
		forever #5 clk = ~clk;
	end

	// Stop a hung run; the limit sits far above the slowest legal run
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic rx_result_t make_result(logic [1:0] kind, logic [7:0] b, logic be,
			logic [7:0] call, logic [31:0] cnt, logic [31:0] peer, logic [2:0] code,
			logic rend);
		rx_result_t r;
		r.kind      = kind;
		r.data_byte = b;
		r.byte_end  = be;
		r.call      = call;
		r.count     = cnt;
		r.peer      = peer;
		r.code      = code;
		r.errors    = err_total;
		r.res_end   = rend;
		return r;
	endfunction

	// Big-endian 32-bit field starting at header byte 'at'
	function automatic logic [31:0] be32(logic [255:0] hdr, int at);
		return {hdr[8*at +: 8], hdr[8*(at+1) +: 8], hdr[8*(at+2) +: 8],
			hdr[8*(at+3) +: 8]};
	endfunction

	// Count the error (saturating) and queue its single result
	function automatic void raise_error(logic [2:0] code);
		if (err_total != '1)
			err_total = err_total + 1;
		results_due.push_back(make_result(KIND_ERROR, '0, 1'b0, '0, '0, '0, code, 1'b1));
	endfunction

	// Advance the deframer image by one accepted beat and queue what it yields
	function automatic void deframe_beat(rx_item_t it);
		logic [255:0] hdr;
		logic [31:0]  dst, src;
		logic [2:0]   fault;
		logic [7:0]   b;
		int           top;
		// Route writes: a 6-bit index always falls inside the 64-entry table
		if (it.cmd) begin
			route_ip[it.tidx] = it.tval;
			return;
		end
		case (rx_state)
			RX_BODY: begin
				// Kept lanes only, low lane first; last marks the highest kept lane
				top = -1;
				for (int i = 0; i < 8; i++)
					if (it.keep[i])
						top = i;
				for (int i = 0; i < 8; i++) begin
					if (it.keep[i])
						results_due.push_back(make_result(KIND_PAYLOAD, it.data[8*i +: 8],
							it.last && (i == top), '0, '0, '0, ERR_NONE, i == top));
				end
				if (it.last)
					rx_state = RX_HEADER;
			end
			RX_DROP: begin
				if (it.last)
					rx_state = RX_HEADER;
			end
			default: begin
				if (it.keep != KEEP_ALL || it.last) begin
					// Short or truncated header word: a last ends the packet outright
					hdr_cnt = 0;
					rx_state = it.last ? RX_HEADER : RX_DROP;
					raise_error(ERR_INCOMPLETE);
				end else if (hdr_cnt < 3) begin
					hdr_words[hdr_cnt] = it.data;
					hdr_cnt++;
				end else begin
					hdr_cnt = 0;
					hdr = {it.data, hdr_words[2], hdr_words[1], hdr_words[0]};
					fault = ERR_NONE;
					for (int i = 0; i < 32; i++) begin
						b = hdr[8*i +: 8];
						if (((i < 4 || i >= 28) && b != MARKER_BYTE) ||
								(i >= 18 && i < 28 && b != 8'h00))
							fault = ERR_MARKER;
					end
					dst = be32(hdr, 4);
					src = be32(hdr, 8);
					// Checks run in order; the first failure wins
					if (fault == ERR_NONE && (src >= RT_DEPTH || route_ip[src[5:0]] != it.ip))
						fault = ERR_IP;
					if (fault == ERR_NONE && dst != node_rank)
						fault = ERR_DST;
					if (fault == ERR_NONE && hdr[8*17 +: 8] != type_code)
						fault = ERR_TYPE;
					if (fault != ERR_NONE) begin
						rx_state = RX_DROP;
						raise_error(fault);
					end else begin
						rx_state = RX_BODY;
						results_due.push_back(make_result(KIND_HEADER, '0, 1'b0,
							hdr[8*16 +: 8], be32(hdr, 12), src, ERR_NONE, 1'b1));
					end
				end
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Driver: present beats from the queue, hold each until it is taken
	// ------------------------------------------------------------------
	rx_item_t cur_item;

	always @(posedge clk) begin : drive_in
		rx_item_t nxt;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				deframe_beat(cur_item);
				accepted_cnt <= accepted_cnt + 1;
			end
			// Only move on once the current beat is gone; a stalled beat stays put
			if (!in_valid || in_ready) begin
				if (beats_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = beats_to_send.pop_front();
					cur_item = nxt;
					in_valid    <= 1'b1;
					command     <= nxt.cmd;
					word_data   <= nxt.data;
					word_keep   <= nxt.keep;
					word_last   <= nxt.last;
					source_ip   <= nxt.ip;
					table_index <= nxt.tidx;
					table_value <= nxt.tval;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver back-pressure, plus one long hold-off so the block fills up
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && !hold_done && accepted_cnt >= HOLD_AFTER) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
	end

	// ------------------------------------------------------------------
	// Monitor: check each result beat against the oldest prediction
	// ------------------------------------------------------------------
	function automatic string show(rx_result_t r);
		return $sformatf(
			"kind=%0d byte=%h blast=%b call=%h count=%h peer=%h code=%0d errs=%0d rlast=%b",
			r.kind, r.data_byte, r.byte_end, r.call, r.count, r.peer, r.code, r.errors,
			r.res_end);
	endfunction

	always @(posedge clk) begin : watch_out
		rx_result_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = '{result_kind, payload_byte, byte_last, call_code, element_count,
				peer_rank, error_code, error_count, result_last};
			if (results_due.size() == 0) begin
				if (mismatch_cnt < REPORT_MAX)
					$display("%0t: unexpected result: %s", $realtime, show(got));
				mismatch_cnt++;
			end else begin
				want = results_due.pop_front();
				if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
						got.byte_end !== want.byte_end || got.call !== want.call ||
						got.count !== want.count || got.peer !== want.peer ||
						got.code !== want.code || got.errors !== want.errors ||
						got.res_end !== want.res_end) begin
					if (mismatch_cnt < REPORT_MAX) begin
						$display("%0t: result mismatch", $realtime);
						$display("  expected %s", show(want));
						$display("  actual   %s", show(got));
					end
					mismatch_cnt++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic push_beat(rx_item_t it);
		beats_to_send.push_back(it);
		planned_beats++;
	endtask

	// Network word; the route fields carry noise the block must ignore
	task automatic push_word(logic [63:0] data, logic [7:0] keep, logic last, logic [31:0] ip);
		push_beat('{1'b0, data, keep, last, ip, 6'($urandom), $urandom});
	endtask

	task automatic push_route(logic [5:0] idx, logic [31:0] val);
		push_beat('{1'b1, rand64(), 8'($urandom), 1'($urandom), $urandom, idx, val});
		ip_of_rank[idx] = val;
	endtask

	// Well-formed 32-byte header image, byte 0 in the low lane
	function automatic logic [255:0] header_image(logic [31:0] dst, logic [31:0] src,
			logic [31:0] size, logic [7:0] call, logic [7:0] typ);
		logic [255:0] h;
		h = '0;
		for (int i = 0; i < 4; i++) begin
			h[8*i +: 8]      = MARKER_BYTE;
			h[8*(28+i) +: 8] = MARKER_BYTE;
		end
		h[8*4 +: 32]  = {dst[7:0], dst[15:8], dst[23:16], dst[31:24]};
		h[8*8 +: 32]  = {src[7:0], src[15:8], src[23:16], src[31:24]};
		h[8*12 +: 32] = {size[7:0], size[15:8], size[23:16], size[31:24]};
		h[8*16 +: 8]  = call;
		h[8*17 +: 8]  = typ;
		return h;
	endfunction

	// Four header beats; bad_lane >= 0 flips one marker or reserved byte.
	// The source address only matters on the fourth beat, so the others carry noise.
	task automatic push_header(logic [31:0] dst, logic [31:0] src, logic [31:0] size,
			logic [7:0] call, logic [7:0] typ, logic [31:0] ip, int bad_lane);
		logic [255:0] h;
		h = header_image(dst, src, size, call, typ);
		if (bad_lane >= 0)
			h[8*bad_lane +: 8] = h[8*bad_lane +: 8] ^ 8'($urandom_range(1, 255));
		for (int w = 0; w < 4; w++)
			push_word(h[64*w +: 64], KEEP_ALL, 1'b0, (w == 3) ? ip : $urandom);
	endtask

	task automatic push_body(int words);
		logic [7:0] keep;
		for (int k = 0; k < words; k++) begin
			keep = ($urandom_range(9) < 7) ? KEEP_ALL : 8'($urandom);
			push_word(rand64(), keep, k == words - 1, $urandom);
		end
	endtask

	// One packet, mostly well-formed, otherwise broken in one of the ways the
	// block must catch, or a stray word or a route write
	task automatic push_random_packet();
		int pick, lane, k, r;
		logic [31:0] dst, src, ip;
		logic [7:0]  typ, keep;
		logic        last;
		logic [255:0] h;
		pick = $urandom_range(0, 13);
		src  = $urandom_range(0, RT_DEPTH - 1);
		ip   = ip_of_rank[src];
		dst  = node_rank;
		typ  = type_code;
		lane = -1;
		case (pick)
			7: begin
				// marker bytes 0..3 and 28..31, reserved bytes 18..27
				r = $urandom_range(0, 17);
				lane = (r < 4) ? r : r + 14;
			end
			8: begin
				if ($urandom_range(1))
					ip = ip ^ $urandom_range(1, 32'hFFFF_FFFF);
				else
					src = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom_range(1000) + RT_DEPTH;
			end
			9:  dst = dst ^ $urandom_range(1, 32'hFFFF_FFFF);
			10: typ = typ ^ 8'($urandom_range(1, 255));
			11: begin
				// Header cut short at a random word, by a partial keep or an early last
				h = header_image(dst, src, $urandom, 8'($urandom), typ);
				k = $urandom_range(0, 3);
				for (int w = 0; w < k; w++)
					push_word(h[64*w +: 64], KEEP_ALL, 1'b0, $urandom);
				r = $urandom_range(0, 2);
				keep = (r == 1) ? KEEP_ALL : 8'($urandom_range(0, 254));
				last = (r != 0);
				push_word(rand64(), keep, last, ip);
				if (!last)
					push_body($urandom_range(1, 2));
				return;
			end
			12: begin
				push_word(rand64(), 8'($urandom), 1'($urandom), $urandom);
				return;
			end
			13: begin
				push_route(6'($urandom), $urandom);
				return;
			end
			default: ;
		endcase
		push_header(dst, src, $urandom, 8'($urandom), typ, ip, lane);
		push_body($urandom_range(1, 3));
	endtask

	task automatic run_random(int unsigned beats);
		int unsigned start;
		start = planned_beats;
		// refresh a few routes so good packets use varied addresses
		for (int i = 0; i < 4; i++)
			push_route(6'($urandom), $urandom);
		while (planned_beats - start < beats)
			push_random_packet();
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_OWN_RANK)
			node_rank = value;
		else
			type_code = value[7:0];
	endtask

	// Wait for every queued beat to be taken and every result to arrive, then
	// give beats without results time to pass through before touching registers
	task automatic settle();
		do
			@(negedge clk);
		while (accepted_cnt != planned_beats || results_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Top extremes first; the block takes writes during its clearing pass
		write_reg(CFG_OWN_RANK, 32'hFFFF_FFFF);
		write_reg(CFG_DATA_TYPE, 32'h0000_00FF);

		send_idle_pct = 26;
		recv_idle_pct = 47;

		// Directed: table ends, a full packet with an empty middle word
		push_route(6'd63, 32'hFFFF_FFFF);
		push_route(6'd0, 32'h0000_0000);
		push_header(32'hFFFF_FFFF, 32'd63, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, -1);
		push_word(rand64(), KEEP_ALL, 1'b0, $urandom);
		push_word(rand64(), 8'h00, 1'b0, $urandom);
		push_word(rand64(), 8'h81, 1'b1, $urandom);
		// source rank just past the table, then drop through the last
		push_header(32'hFFFF_FFFF, RT_DEPTH, 32'h1, 8'h00, 8'hFF, 32'h0, -1);
		push_word(rand64(), KEEP_ALL, 1'b1, $urandom);
		// partial keep on the first header word: discard up to the next last
		push_word(rand64(), 8'h7F, 1'b0, $urandom);
		push_word(rand64(), 8'hFF, 1'b0, $urandom);
		push_word(rand64(), 8'h01, 1'b1, $urandom);
		// header ended early by last: the next beat starts a fresh header
		push_word({8'h00, 24'h0, {4{MARKER_BYTE}}}, KEEP_ALL, 1'b0, $urandom);
		push_word(rand64(), KEEP_ALL, 1'b0, $urandom);
		push_word(rand64(), KEEP_ALL, 1'b1, $urandom);
		// size zero, rank zero, and a message that ends on a word with no kept byte
		push_header(32'hFFFF_FFFF, 32'd0, 32'h0, 8'h00, 8'hFF, 32'h0, -1);
		push_word(rand64(), 8'h00, 1'b1, $urandom);

		run_random(32);
		settle();

		// Bottom extremes, idling swapped
		write_reg(CFG_OWN_RANK, 32'h0);
		write_reg(CFG_DATA_TYPE, 32'h0);
		send_idle_pct = 47;
		recv_idle_pct = 26;
		run_random(32);
		settle();

		// Random settings; upper data bits on the type write must be dropped
		write_reg(CFG_OWN_RANK, $urandom);
		write_reg(CFG_DATA_TYPE, $urandom);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(32);
		settle();

		@(negedge clk);
		if (mismatch_cnt == 0 && results_due.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
